@@ design/lazy_range_add_segment_tree_macros.svh @@
// ----------------------------------------------------------------------------
// lazy_range_add_segment_tree_macros.svh
// Assertion macros used by the checker file.
// ----------------------------------------------------------------------------
`ifndef LAZY_RANGE_ADD_SEGMENT_TREE_MACROS_SVH
`define LAZY_RANGE_ADD_SEGMENT_TREE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LRAST_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrast: assertion failed");

// antecedent implies consequent in the next cycle
`define LRAST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrast: assertion failed");

`endif

@@ design/lrast_pkg.sv @@
// ----------------------------------------------------------------------------
// lrast_pkg
// Shared types, constants and the combine function of the segment tree.
// ----------------------------------------------------------------------------
`default_nettype none

package lrast_pkg;

  localparam int LEAVES = 1024;
  localparam int LOGP   = $clog2(LEAVES);
  localparam int SPAN   = 1 << LOGP;
  localparam int NODES  = 2 * SPAN;
  localparam int NODE_W = LOGP + 1;
  localparam int LVL_W  = $clog2(LOGP + 1);
  localparam int KIND_W = 3;
  localparam int LO_W   = 10;
  localparam int HI_W   = 11;
  localparam int VAL_W  = 32;

  localparam logic [KIND_W-1:0] KIND_LOAD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BUILD  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ADD    = 3'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ASSIGN = 3'd4;

  localparam logic CFG_MODE  = 1'b0;
  localparam logic CFG_IDENT = 1'b1;

  localparam logic [HI_W-1:0] LEAVES_C = HI_W'(LEAVES);

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_BUILD,
    OP_ADD,
    OP_QUERY,
    OP_EMPTYQ,
    OP_ASSIGN
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [LO_W-1:0]  lo;
    logic [HI_W-1:0]  hi;
    logic [VAL_W-1:0] value;
  } item_t;

  typedef struct packed {
    logic             mode;
    logic [VAL_W-1:0] ident;
  } cfg_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } eng_status_t;

  typedef enum logic [4:0] {
    E_CLEAR,
    E_IDLE,
    E_DISPATCH,
    E_ENTER,
    E_VISIT,
    E_KIDS,
    E_DOWN,
    E_RETURN,
    E_POST_L,
    E_POST_R,
    E_ST_RD,
    E_ST_WR,
    E_ST_CL,
    E_ST_CR,
    E_CB_RA,
    E_CB_RB,
    E_CB_WR,
    E_BLD_S,
    E_BLD_SN,
    E_BLD_C,
    E_BLD_CN,
    E_FINISH
  } eng_state_t;

  function automatic logic [VAL_W-1:0] comb_fn(input logic mode,
                                               input logic [VAL_W-1:0] a,
                                               input logic [VAL_W-1:0] b);
    if (mode) begin
      return a + b;
    end
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

endpackage

`default_nettype wire

@@ design/lrast_ram.sv @@
// ----------------------------------------------------------------------------
// lrast_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrast_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ design/lrast_front.sv @@
// ----------------------------------------------------------------------------
// lrast_front
// Accepts items, clamps and classifies them, and queues them for the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module lrast_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [lrast_pkg::KIND_W-1:0] in_kind,
  input  wire logic [lrast_pkg::LO_W-1:0]   in_index_lo,
  input  wire logic [lrast_pkg::HI_W-1:0]   in_index_hi,
  input  wire logic [lrast_pkg::VAL_W-1:0]  in_value,
  input  wire lrast_pkg::eng_status_t       status,
  output logic                             q_valid,
  output lrast_pkg::item_t                 q_item
);
  import lrast_pkg::*;

  item_t           q_r [2];
  logic            wptr_r, wptr_nxt;
  logic            rptr_r, rptr_nxt;
  logic [1:0]      cnt_r, cnt_nxt;
  logic            push;
  logic [HI_W-1:0] hi_c;
  item_t           cls;

  always_comb begin
    hi_c = (in_index_hi > LEAVES_C) ? LEAVES_C : in_index_hi;
    cls.lo    = in_index_lo;
    cls.hi    = hi_c;
    cls.value = in_value;
    case (in_kind)
      KIND_LOAD:   cls.op = (HI_W'(in_index_lo) < LEAVES_C) ? OP_LOAD : OP_NOP;
      KIND_BUILD:  cls.op = OP_BUILD;
      KIND_ADD:    cls.op = (HI_W'(in_index_lo) < hi_c) ? OP_ADD : OP_NOP;
      KIND_QUERY:  cls.op = (HI_W'(in_index_lo) < hi_c) ? OP_QUERY : OP_EMPTYQ;
      KIND_ASSIGN: cls.op = (HI_W'(in_index_lo) < LEAVES_C) ? OP_ASSIGN : OP_NOP;
      default:     cls.op = OP_NOP;
    endcase
  end

  assign busy    = (cnt_r == 2'd2) || status.clearing;
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_item  = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = status.pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r + 2'(push) - 2'(status.pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

@@ design/lrast_engine.sv @@
// ----------------------------------------------------------------------------
// lrast_engine
// Walks the tree one node operation at a time over the node and pending RAMs.
// ----------------------------------------------------------------------------
`default_nettype none

module lrast_engine (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lrast_pkg::cfg_t             cfg,
  input  wire logic                        q_valid,
  input  wire lrast_pkg::item_t            q_item,
  output lrast_pkg::eng_status_t           status,
  output logic                             out_strobe,
  output logic [lrast_pkg::VAL_W-1:0]      out_answer,
  output logic                             out_answer_valid
);
  import lrast_pkg::*;

  eng_state_t        state_r, state_nxt;
  eng_state_t        cont_r, cont_nxt;
  logic [NODE_W-1:0] v_r, v_nxt;
  logic [LVL_W-1:0]  lvl_r, lvl_nxt;
  logic [NODE_W-1:0] sn_r, sn_nxt;
  logic [LVL_W-1:0]  slvl_r, slvl_nxt;
  logic [VAL_W-1:0]  p_r, p_nxt;
  logic [VAL_W-1:0]  sv_r, sv_nxt;
  logic [VAL_W-1:0]  ra_r, ra_nxt;
  logic [VAL_W-1:0]  acc_r, acc_nxt;
  logic              acc_has_r, acc_has_nxt;
  item_t             item_r, item_nxt;
  logic              strobe_r, strobe_nxt;
  logic [VAL_W-1:0]  ans_r, ans_nxt;
  logic              ansv_r, ansv_nxt;

  logic              val_we, pend_we;
  logic [NODE_W-1:0] val_waddr, pend_waddr, val_raddr, pend_raddr;
  logic [VAL_W-1:0]  val_wdata, pend_wdata, val_rdata, pend_rdata;

  logic [LVL_W-1:0]  sh, ssh, bit_idx;
  logic [HI_W-1:0]   len_w, r_w;
  logic [LO_W-1:0]   l_w, lo_shr;
  logic              outside_w, covered_w, leaf_w;
  logic [VAL_W-1:0]  delta;
  logic [NODE_W-1:0] v_inc;

  lrast_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  lrast_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  always_comb begin
    sh        = LVL_W'(LOGP) - lvl_r;
    len_w     = HI_W'(1) << sh;
    l_w       = LO_W'(v_r << sh);
    r_w       = HI_W'(l_w) + len_w;
    outside_w = (item_r.hi <= HI_W'(l_w)) || (r_w <= HI_W'(item_r.lo));
    covered_w = (item_r.lo <= l_w) && (r_w <= item_r.hi);
    leaf_w    = (lvl_r == LVL_W'(LOGP));
    ssh       = LVL_W'(LOGP) - slvl_r;
    delta     = cfg.mode ? (pend_rdata << ssh) : pend_rdata;
    bit_idx   = LVL_W'(LOGP - 1) - lvl_r;
    lo_shr    = item_r.lo >> bit_idx;
    v_inc     = v_r + NODE_W'(1);

    state_nxt   = state_r;
    cont_nxt    = cont_r;
    v_nxt       = v_r;
    lvl_nxt     = lvl_r;
    sn_nxt      = sn_r;
    slvl_nxt    = slvl_r;
    p_nxt       = p_r;
    sv_nxt      = sv_r;
    ra_nxt      = ra_r;
    acc_nxt     = acc_r;
    acc_has_nxt = acc_has_r;
    item_nxt    = item_r;
    strobe_nxt  = 1'b0;
    ans_nxt     = ans_r;
    ansv_nxt    = 1'b0;
    status.pop      = 1'b0;
    status.clearing = 1'b0;
    val_we      = 1'b0;
    pend_we     = 1'b0;
    val_waddr   = sn_r;
    pend_waddr  = sn_r;
    val_wdata   = '0;
    pend_wdata  = '0;
    val_raddr   = sn_r;
    pend_raddr  = sn_r;

    case (state_r)
      E_CLEAR: begin
        status.clearing = 1'b1;
        val_we     = 1'b1;
        pend_we    = 1'b1;
        val_waddr  = v_r;
        pend_waddr = v_r;
        if (v_r == NODE_W'(NODES - 1)) begin
          state_nxt = E_IDLE;
        end else begin
          v_nxt = v_inc;
        end
      end
      E_IDLE: begin
        if (q_valid) begin
          status.pop = 1'b1;
          item_nxt   = q_item;
          state_nxt  = E_DISPATCH;
        end
      end
      E_DISPATCH: begin
        v_nxt       = NODE_W'(1);
        lvl_nxt     = '0;
        acc_has_nxt = 1'b0;
        case (item_r.op)
          OP_LOAD: begin
            val_we     = 1'b1;
            pend_we    = 1'b1;
            val_waddr  = NODE_W'(SPAN) + NODE_W'(item_r.lo);
            pend_waddr = NODE_W'(SPAN) + NODE_W'(item_r.lo);
            val_wdata  = item_r.value;
            state_nxt  = E_FINISH;
          end
          OP_BUILD:  state_nxt = E_BLD_S;
          OP_ADD, OP_QUERY, OP_ASSIGN: state_nxt = E_ENTER;
          OP_EMPTYQ: begin
            acc_nxt   = cfg.ident;
            state_nxt = E_FINISH;
          end
          default:   state_nxt = E_FINISH;
        endcase
      end
      E_ENTER: begin
        if (item_r.op != OP_ASSIGN && outside_w) begin
          if (item_r.op == OP_QUERY) begin
            acc_nxt     = acc_has_r ? comb_fn(cfg.mode, acc_r, cfg.ident) : cfg.ident;
            acc_has_nxt = 1'b1;
          end
          state_nxt = E_RETURN;
        end else begin
          sn_nxt    = v_r;
          slvl_nxt  = lvl_r;
          cont_nxt  = E_VISIT;
          state_nxt = E_ST_RD;
        end
      end
      E_VISIT: begin
        if (item_r.op == OP_ADD && covered_w) begin
          pend_we    = 1'b1;
          pend_waddr = v_r;
          pend_wdata = item_r.value;
          state_nxt  = E_RETURN;
        end else if (item_r.op == OP_QUERY && covered_w) begin
          acc_nxt     = acc_has_r ? comb_fn(cfg.mode, acc_r, sv_r) : sv_r;
          acc_has_nxt = 1'b1;
          state_nxt   = E_RETURN;
        end else if (item_r.op == OP_ASSIGN && leaf_w) begin
          val_we    = 1'b1;
          val_waddr = v_r;
          val_wdata = item_r.value;
          state_nxt = E_RETURN;
        end else if (item_r.op == OP_ADD) begin
          v_nxt     = {v_r[NODE_W-2:0], 1'b0};
          lvl_nxt   = lvl_r + LVL_W'(1);
          state_nxt = E_ENTER;
        end else begin
          sn_nxt    = {v_r[NODE_W-2:0], 1'b0};
          slvl_nxt  = lvl_r + LVL_W'(1);
          cont_nxt  = E_KIDS;
          state_nxt = E_ST_RD;
        end
      end
      E_KIDS: begin
        sn_nxt    = {v_r[NODE_W-2:0], 1'b1};
        slvl_nxt  = lvl_r + LVL_W'(1);
        cont_nxt  = E_DOWN;
        state_nxt = E_ST_RD;
      end
      E_DOWN: begin
        lvl_nxt   = lvl_r + LVL_W'(1);
        state_nxt = E_ENTER;
        if (item_r.op == OP_ASSIGN) begin
          v_nxt = {v_r[NODE_W-2:0], lo_shr[0]};
        end else begin
          v_nxt = {v_r[NODE_W-2:0], 1'b0};
        end
      end
      E_RETURN: begin
        if (v_r == NODE_W'(1)) begin
          state_nxt = E_FINISH;
        end else if (item_r.op == OP_ASSIGN) begin
          v_nxt     = v_r >> 1;
          lvl_nxt   = lvl_r - LVL_W'(1);
          cont_nxt  = E_RETURN;
          state_nxt = E_CB_RA;
        end else if (!v_r[0]) begin
          v_nxt     = v_inc;
          state_nxt = E_ENTER;
        end else if (item_r.op == OP_ADD) begin
          v_nxt     = v_r >> 1;
          lvl_nxt   = lvl_r - LVL_W'(1);
          sn_nxt    = {v_r[NODE_W-1:1], 1'b0};
          slvl_nxt  = lvl_r;
          cont_nxt  = E_POST_L;
          state_nxt = E_ST_RD;
        end else begin
          v_nxt   = v_r >> 1;
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end
      E_POST_L: begin
        sn_nxt    = {v_r[NODE_W-2:0], 1'b1};
        slvl_nxt  = lvl_r + LVL_W'(1);
        cont_nxt  = E_POST_R;
        state_nxt = E_ST_RD;
      end
      E_POST_R: begin
        cont_nxt  = E_RETURN;
        state_nxt = E_CB_RA;
      end
      E_ST_RD: begin
        state_nxt = E_ST_WR;
      end
      E_ST_WR: begin
        p_nxt      = pend_rdata;
        sv_nxt     = val_rdata + delta;
        val_we     = 1'b1;
        val_wdata  = val_rdata + delta;
        pend_we    = 1'b1;
        pend_wdata = '0;
        pend_raddr = {sn_r[NODE_W-2:0], 1'b0};
        state_nxt  = (slvl_r == LVL_W'(LOGP)) ? cont_r : E_ST_CL;
      end
      E_ST_CL: begin
        pend_we    = 1'b1;
        pend_waddr = {sn_r[NODE_W-2:0], 1'b0};
        pend_wdata = pend_rdata + p_r;
        pend_raddr = {sn_r[NODE_W-2:0], 1'b1};
        state_nxt  = E_ST_CR;
      end
      E_ST_CR: begin
        pend_we    = 1'b1;
        pend_waddr = {sn_r[NODE_W-2:0], 1'b1};
        pend_wdata = pend_rdata + p_r;
        state_nxt  = cont_r;
      end
      E_CB_RA: begin
        val_raddr = {v_r[NODE_W-2:0], 1'b0};
        state_nxt = E_CB_RB;
      end
      E_CB_RB: begin
        ra_nxt    = val_rdata;
        val_raddr = {v_r[NODE_W-2:0], 1'b1};
        state_nxt = E_CB_WR;
      end
      E_CB_WR: begin
        val_we    = 1'b1;
        val_waddr = v_r;
        val_wdata = comb_fn(cfg.mode, ra_r, val_rdata);
        state_nxt = cont_r;
      end
      E_BLD_S: begin
        sn_nxt    = v_r;
        slvl_nxt  = lvl_r;
        cont_nxt  = E_BLD_SN;
        state_nxt = E_ST_RD;
      end
      E_BLD_SN: begin
        if (v_r == NODE_W'(NODES - 1)) begin
          v_nxt     = NODE_W'(SPAN - 1);
          state_nxt = E_BLD_C;
        end else begin
          v_nxt     = v_inc;
          state_nxt = E_BLD_S;
          if ((v_inc & v_r) == '0) begin
            lvl_nxt = lvl_r + LVL_W'(1);
          end
        end
      end
      E_BLD_C: begin
        cont_nxt  = E_BLD_CN;
        state_nxt = E_CB_RA;
      end
      E_BLD_CN: begin
        if (v_r == NODE_W'(1)) begin
          state_nxt = E_FINISH;
        end else begin
          v_nxt     = v_r - NODE_W'(1);
          state_nxt = E_BLD_C;
        end
      end
      E_FINISH: begin
        strobe_nxt = 1'b1;
        if (item_r.op == OP_QUERY || item_r.op == OP_EMPTYQ) begin
          ansv_nxt = 1'b1;
          ans_nxt  = acc_r;
        end else begin
          ans_nxt = '0;
        end
        state_nxt = E_IDLE;
      end
      default: state_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= E_CLEAR;
      cont_r    <= E_IDLE;
      v_r       <= '0;
      lvl_r     <= '0;
      acc_has_r <= 1'b0;
      strobe_r  <= 1'b0;
      ansv_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cont_r    <= cont_nxt;
      v_r       <= v_nxt;
      lvl_r     <= lvl_nxt;
      acc_has_r <= acc_has_nxt;
      strobe_r  <= strobe_nxt;
      ansv_r    <= ansv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sn_r   <= sn_nxt;
    slvl_r <= slvl_nxt;
    p_r    <= p_nxt;
    sv_r   <= sv_nxt;
    ra_r   <= ra_nxt;
    acc_r  <= acc_nxt;
    item_r <= item_nxt;
    ans_r  <= ans_nxt;
  end

  assign out_strobe       = strobe_r;
  assign out_answer       = ans_r;
  assign out_answer_valid = ansv_r;

endmodule

`default_nettype wire

@@ design/lazy_range_add_segment_tree.sv @@
// Range add, query and assign settle the nodes on their path, and add and assign
//   recombine parents, one access at a time over the one read port of the node and
//   pending RAMs; build settles every node, then recombines every inner node.
// Throughput: one item at a time in the engine; a two-entry queue takes items ahead.
// Reset: synchronous; a clearing pass over every node of both RAMs holds busy high.
// ----------------------------------------------------------------------------
// lazy_range_add_segment_tree
// Segment tree with lazy range add and max or sum range query.
// ----------------------------------------------------------------------------
`default_nettype none

module lazy_range_add_segment_tree (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [lrast_pkg::KIND_W-1:0] in_kind,
  input  wire logic [lrast_pkg::LO_W-1:0]   in_index_lo,
  input  wire logic [lrast_pkg::HI_W-1:0]   in_index_hi,
  input  wire logic [lrast_pkg::VAL_W-1:0]  in_value,
  output logic                             out_strobe,
  output logic [lrast_pkg::VAL_W-1:0]      out_answer,
  output logic                             out_answer_valid,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [lrast_pkg::VAL_W-1:0]  cfg_wdata
);
  import lrast_pkg::*;

  logic        mode_r;
  logic [VAL_W-1:0] ident_r;
  cfg_t        cfg;
  eng_status_t status;
  logic        q_valid;
  item_t       q_item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      ident_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:  mode_r  <= cfg_wdata[0];
        CFG_IDENT: ident_r <= cfg_wdata;
        default:   mode_r  <= mode_r;
      endcase
    end
  end

  assign cfg.mode  = mode_r;
  assign cfg.ident = ident_r;

  lrast_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_kind     (in_kind),
    .in_index_lo (in_index_lo),
    .in_index_hi (in_index_hi),
    .in_value    (in_value),
    .status      (status),
    .q_valid     (q_valid),
    .q_item      (q_item)
  );

  lrast_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .status           (status),
    .out_strobe       (out_strobe),
    .out_answer       (out_answer),
    .out_answer_valid (out_answer_valid)
  );

endmodule

`default_nettype wire

@@ design/lrast_checker.sv @@
// ----------------------------------------------------------------------------
// lrast_checker
// Port-level checks of the segment tree, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lazy_range_add_segment_tree_macros.svh"

module lrast_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        busy,
  input wire logic        out_strobe,
  input wire logic [31:0] out_answer,
  input wire logic        out_answer_valid
);

  `LRAST_ASSERT_SAME(a_valid_with_strobe, out_answer_valid, out_strobe)
  `LRAST_ASSERT_SAME(a_zero_when_no_answer, out_strobe && !out_answer_valid, out_answer == 32'd0)
  `LRAST_ASSERT_NEXT(a_strobe_spacing, out_strobe, !out_strobe)
  `LRAST_ASSERT_SAME(a_busy_after_reset, $rose(rst_n), busy)

endmodule

bind lazy_range_add_segment_tree lrast_checker u_chk (.*);

`default_nettype wire

@@ dv/tb_lazy_range_add_segment_tree.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lazy_range_add_segment_tree
// Drives load, build, range add, range query and assign commands into the
// segment tree under changing combine modes and identity values. Checks every
// result against a lazy segment tree kept in the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lazy_range_add_segment_tree;
  import lrast_pkg::*;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LO_W-1:0]   lo;
    logic [HI_W-1:0]   hi;
    logic [VAL_W-1:0]  value;
  } tree_cmd_t;

  typedef struct packed {
    logic [VAL_W-1:0] answer;
    logic             valid;
  } tree_answer_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [KIND_W-1:0] in_kind;
  logic [LO_W-1:0] in_index_lo;
  logic [HI_W-1:0] in_index_hi;
  logic [VAL_W-1:0] in_value;
  logic out_strobe;
  logic [VAL_W-1:0] out_answer;
  logic out_answer_valid;
  logic cfg_we;
  logic cfg_index;
  logic [VAL_W-1:0] cfg_wdata;

  tree_cmd_t cmd_q[$];
  tree_answer_t answer_q[$];
  int err_cnt = 0;
  int idle_pct = 0;
  logic hold = 1'b0;

  logic [VAL_W-1:0] node_val[0:NODES-1];
  logic [VAL_W-1:0] node_pend[0:NODES-1];
  logic sum_mode;
  logic [VAL_W-1:0] ident_val;

  lazy_range_add_segment_tree i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_index_lo(in_index_lo), .in_index_hi(in_index_hi),
    .in_value(in_value), .out_strobe(out_strobe), .out_answer(out_answer),
    .out_answer_valid(out_answer_valid), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  initial begin
    #20_000_000;
    $display("tb_lazy_range_add_segment_tree: errors");
    $finish;
  end

  function automatic logic [VAL_W-1:0] merge(logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
    if (sum_mode) begin
      return a + b;
    end
    return ($signed(a) >= $signed(b)) ? a : b;
  endfunction

  function automatic void push_down(int v, int len);
    logic [VAL_W-1:0] p;
    p = node_pend[v];
    node_val[v] = sum_mode ? node_val[v] + p * VAL_W'(len) : node_val[v] + p;
    if (len > 1) begin
      node_pend[2*v] = node_pend[2*v] + p;
      node_pend[2*v+1] = node_pend[2*v+1] + p;
    end
    node_pend[v] = '0;
  endfunction

  function automatic void add_range(int v, int l, int r, int sl, int sr,
                                    logic [VAL_W-1:0] x);
    int m;
    if (sr <= l || r <= sl) return;
    push_down(v, r - l);
    if (sl <= l && r <= sr) begin
      node_pend[v] = node_pend[v] + x;
      return;
    end
    m = l + (r - l) / 2;
    add_range(2*v, l, m, sl, sr, x);
    add_range(2*v+1, m, r, sl, sr, x);
    push_down(2*v, m - l);
    push_down(2*v+1, r - m);
    node_val[v] = merge(node_val[2*v], node_val[2*v+1]);
  endfunction

  function automatic logic [VAL_W-1:0] query_range(int v, int l, int r, int sl, int sr);
    int m;
    if (sr <= l || r <= sl) return ident_val;
    push_down(v, r - l);
    if (sl <= l && r <= sr) return node_val[v];
    m = l + (r - l) / 2;
    push_down(2*v, m - l);
    push_down(2*v+1, r - m);
    return merge(query_range(2*v, l, m, sl, sr), query_range(2*v+1, m, r, sl, sr));
  endfunction

  function automatic void set_leaf(int v, int l, int r, int i, logic [VAL_W-1:0] x);
    int m;
    push_down(v, r - l);
    if (r - l == 1) begin
      node_val[v] = x;
      return;
    end
    m = l + (r - l) / 2;
    push_down(2*v, m - l);
    push_down(2*v+1, r - m);
    if (i < m) set_leaf(2*v, l, m, i, x);
    else set_leaf(2*v+1, m, r, i, x);
    node_val[v] = merge(node_val[2*v], node_val[2*v+1]);
  endfunction

  function automatic void rebuild();
    int len;
    len = SPAN;
    for (int first = 1; first < 2 * SPAN; first = first << 1) begin
      for (int v = first; v < 2 * first; v++) push_down(v, len);
      len = len >> 1;
    end
    for (int v = SPAN - 1; v > 0; v--) node_val[v] = merge(node_val[2*v], node_val[2*v+1]);
  endfunction

  function automatic tree_answer_t predict_answer(tree_cmd_t c);
    tree_answer_t a;
    int lo, hi;
    a = '0;
    lo = int'(c.lo);
    hi = (c.hi > LEAVES_C) ? LEAVES : int'(c.hi);
    case (c.kind)
      KIND_LOAD: begin
        if (lo < LEAVES) begin
          node_val[SPAN + lo] = c.value;
          node_pend[SPAN + lo] = '0;
        end
      end
      KIND_BUILD: rebuild();
      KIND_ADD: if (lo < hi) add_range(1, 0, SPAN, lo, hi, c.value);
      KIND_QUERY: begin
        a.valid = 1'b1;
        a.answer = (lo < hi) ? query_range(1, 0, SPAN, lo, hi) : ident_val;
      end
      KIND_ASSIGN: if (lo < LEAVES) set_leaf(1, 0, SPAN, lo, c.value);
      default: ;
    endcase
    return a;
  endfunction

  task automatic report(string what);
    $display("mismatch at %0t: %s", $time, what);
    err_cnt++;
  endtask

  // driver: start stays high until the transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_kind <= '0;
      in_index_lo <= '0;
      in_index_hi <= '0;
      in_value <= '0;
    end else begin
      if (start && !busy) begin
        answer_q.push_back(predict_answer({in_kind, in_index_lo, in_index_hi, in_value}));
      end
      if (!start || !busy) begin
        if (cmd_q.size() > 0 && !hold && $urandom_range(99) >= idle_pct) begin
          tree_cmd_t c;
          c = cmd_q.pop_front();
          in_kind <= c.kind;
          in_index_lo <= c.lo;
          in_index_hi <= c.hi;
          in_value <= c.value;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (answer_q.size() == 0) begin
        report("result with nothing expected");
      end else begin
        tree_answer_t e;
        e = answer_q.pop_front();
        if (out_answer_valid !== e.valid)
          report($sformatf("answer_valid %b, expected %b", out_answer_valid, e.valid));
        if (out_answer !== e.answer)
          report($sformatf("answer %h, expected %h", out_answer, e.answer));
      end
    end
  end

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return VAL_W'($urandom_range(20)) - 32'd10;
      default: return $urandom;
    endcase
  endfunction

  function automatic tree_cmd_t rand_cmd();
    tree_cmd_t c;
    int sel;
    sel = $urandom_range(999);
    c.lo = LO_W'($urandom_range(SPAN - 1));
    case ($urandom_range(9))
      0: c.hi = HI_W'($urandom_range(2047));
      1: c.hi = HI_W'($urandom_range(c.lo));
      2: c.hi = LEAVES_C;
      default: c.hi = HI_W'(c.lo) + HI_W'($urandom_range(1, 64));
    endcase
    c.value = rand_value();
    if (sel < 10) c.kind = KIND_BUILD;
    else if (sel < 130) c.kind = KIND_LOAD;
    else if (sel < 430) c.kind = KIND_ADD;
    else if (sel < 800) c.kind = KIND_QUERY;
    else if (sel < 970) c.kind = KIND_ASSIGN;
    else c.kind = KIND_W'($urandom_range(5, 7));
    return c;
  endfunction

  task automatic wait_idle();
    while (cmd_q.size() > 0 || start || answer_q.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [VAL_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    if (idx == CFG_MODE) sum_mode = d[0];
    else ident_val = d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [VAL_W-1:0] idents[6];
    int pcts[3];
    idents = '{32'h0, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h1234_5678};
    pcts = '{25, 51, 0};
    for (int i = 0; i < NODES; i++) begin
      node_val[i] = '0;
      node_pend[i] = '0;
    end
    sum_mode = 1'b0;
    ident_val = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_MODE;
    cfg_wdata = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: extremes, every kind, clamped and empty ranges
    cmd_q.push_back('{KIND_QUERY, 10'd0, 11'd1024, 32'h0});
    cmd_q.push_back('{KIND_LOAD, 10'd0, 11'd0, 32'h7fff_ffff});
    cmd_q.push_back('{KIND_LOAD, 10'd1023, 11'd0, 32'h8000_0000});
    cmd_q.push_back('{KIND_LOAD, 10'd512, 11'd0, 32'hffff_ffff});
    cmd_q.push_back('{KIND_BUILD, 10'd0, 11'd0, 32'h0});
    cmd_q.push_back('{KIND_QUERY, 10'd0, 11'd2047, 32'h0});
    cmd_q.push_back('{KIND_QUERY, 10'd1023, 11'd1024, 32'h0});
    cmd_q.push_back('{KIND_QUERY, 10'd5, 11'd5, 32'h0});
    cmd_q.push_back('{KIND_QUERY, 10'd900, 11'd3, 32'h0});
    cmd_q.push_back('{KIND_ADD, 10'd0, 11'd1024, 32'h0000_0001});
    cmd_q.push_back('{KIND_ADD, 10'd7, 11'd7, 32'h5555_5555});
    cmd_q.push_back('{KIND_ADD, 10'd300, 11'd2047, 32'h8000_0000});
    cmd_q.push_back('{KIND_QUERY, 10'd0, 11'd1024, 32'h0});
    cmd_q.push_back('{KIND_QUERY, 10'd511, 11'd513, 32'h0});
    cmd_q.push_back('{KIND_ASSIGN, 10'd0, 11'd0, 32'h8000_0000});
    cmd_q.push_back('{KIND_ASSIGN, 10'd1023, 11'd0, 32'h7fff_ffff});
    cmd_q.push_back('{KIND_QUERY, 10'd0, 11'd1, 32'h0});
    cmd_q.push_back('{KIND_QUERY, 10'd1000, 11'd1024, 32'h0});
    cmd_q.push_back('{3'd5, 10'h3ff, 11'h7ff, 32'hffff_ffff});
    cmd_q.push_back('{3'd6, 10'd1, 11'd2, 32'h1});
    cmd_q.push_back('{3'd7, 10'd0, 11'd0, 32'h0});
    cmd_q.push_back('{KIND_BUILD, 10'd0, 11'd0, 32'h0});
    cmd_q.push_back('{KIND_QUERY, 10'd0, 11'd1024, 32'h0});
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(CFG_MODE, VAL_W'(ph % 2));
      write_cfg(CFG_IDENT, idents[ph]);
      idle_pct = pcts[ph % 3];
      for (int n = 0; n < 230; n++) cmd_q.push_back(rand_cmd());
      cmd_q.push_back('{KIND_BUILD, 10'd0, 11'd0, 32'h0});
      if (ph == 2) begin
        while (cmd_q.size() > 100) @(posedge clk);
        hold = 1'b1;
        while (start || answer_q.size() > 0) @(posedge clk);
        hold = 1'b0;
      end
      wait_idle();
    end

    repeat (50) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb_lazy_range_add_segment_tree: clean");
    end else begin
      $display("tb_lazy_range_add_segment_tree: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ lazy_range_add_segment_tree.f @@
+incdir+design
design/lrast_pkg.sv
design/lrast_ram.sv
design/lrast_front.sv
design/lrast_engine.sv
design/lazy_range_add_segment_tree.sv
design/lrast_checker.sv
dv/tb_lazy_range_add_segment_tree.sv
